/* src/lea_pkg.sv */
// Shared types, constants and helper functions for the LEA-128 encryption block.
// No dependencies; used by lea_round, lea128_block_encrypt and lea128_block_encrypt_chk.
`default_nettype none

package lea_pkg;

   // Word and state types
   localparam int WORD_WIDTH   = 32;
   localparam int WORD_COUNT   = 4;
   localparam int ROUND_WIDTH  = 5;
   localparam int MAX_ROUNDS   = 24;
   localparam int DEF_ROUNDS   = 24;
   localparam int CSR_IDX_WIDTH = 2;

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef word_type [WORD_COUNT-1:0] quad_type;
   typedef logic [ROUND_WIDTH-1:0] round_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_KEY_WORD_0 = 2'd0,
      CSR_KEY_WORD_1 = 2'd1,
      CSR_KEY_WORD_2 = 2'd2,
      CSR_KEY_WORD_3 = 2'd3
   } csr_index_type;

   // Sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // Standard key schedule constants
   localparam word_type DELTA [WORD_COUNT] = '{
      32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec
   };

   // Rotations of the key schedule words and of the round function
   localparam round_type KEY_ROT_0 = 5'd1;
   localparam round_type KEY_ROT_1 = 5'd3;
   localparam round_type KEY_ROT_2 = 5'd6;
   localparam round_type KEY_ROT_3 = 5'd11;
   localparam round_type RND_ROT_0 = 5'd9;
   localparam round_type RND_ROT_1 = 5'd27;  // right by 5
   localparam round_type RND_ROT_2 = 5'd29;  // right by 3

   // Rotate a word left by an amount modulo 32.
   function automatic word_type rotl(word_type v, round_type n);
      logic [2*WORD_WIDTH-1:0] w;
      w = {v, v} << n;
      return w[2*WORD_WIDTH-1:WORD_WIDTH];
   endfunction

   // Delta constant of a round, rotated left by the round index plus a word offset.
   function automatic word_type delta_rot(round_type r, round_type k);
      return rotl(DELTA[r[1:0]], round_type'(r + k));
   endfunction

endpackage

`default_nettype wire

/* src/lea_round.sv */
// One LEA-128 round: the on-the-fly key schedule step followed by the round function.
// Depends on lea_pkg; instantiated once by lea128_block_encrypt and reused every round.
`default_nettype none

module lea_round (
   input  wire lea_pkg::round_type round_idx,
   input  wire lea_pkg::quad_type  state_cur,
   input  wire lea_pkg::quad_type  key_cur,
   output lea_pkg::quad_type       state_nxt,
   output lea_pkg::quad_type       key_nxt
);

   lea_pkg::quad_type rk;

   // Next round key words
   always_comb begin
      rk[0] = lea_pkg::rotl(key_cur[0] + lea_pkg::delta_rot(round_idx, 5'd0),
                            lea_pkg::KEY_ROT_0);
      rk[1] = lea_pkg::rotl(key_cur[1] + lea_pkg::delta_rot(round_idx, 5'd1),
                            lea_pkg::KEY_ROT_1);
      rk[2] = lea_pkg::rotl(key_cur[2] + lea_pkg::delta_rot(round_idx, 5'd2),
                            lea_pkg::KEY_ROT_2);
      rk[3] = lea_pkg::rotl(key_cur[3] + lea_pkg::delta_rot(round_idx, 5'd3),
                            lea_pkg::KEY_ROT_3);
   end

   assign key_nxt = rk;

   // Round function; word 1 of the round key is used three times.
   always_comb begin
      state_nxt[0] = lea_pkg::rotl((state_cur[0] ^ rk[0]) + (state_cur[1] ^ rk[1]),
                                   lea_pkg::RND_ROT_0);
      state_nxt[1] = lea_pkg::rotl((state_cur[1] ^ rk[2]) + (state_cur[2] ^ rk[1]),
                                   lea_pkg::RND_ROT_1);
      state_nxt[2] = lea_pkg::rotl((state_cur[2] ^ rk[3]) + (state_cur[3] ^ rk[1]),
                                   lea_pkg::RND_ROT_2);
      state_nxt[3] = state_cur[0];
   end

endmodule

`default_nettype wire

/* src/lea128_block_encrypt.sv */
// Top level of the LEA-128 encryption block: key registers, round sequencer, output register.
// Depends on lea_pkg and lea_round.
`default_nettype none

// LEA-128 block encryption with one result item per round. The key is written as four
// little-endian words through the csr_ port; the user must write it only while the block is
// idle, which the block itself does not enforce. It is latched at the start of each block. A
// plaintext item on req_ is taken when the block is idle; the single round unit then runs one
// round per cycle unless rsp_ stalls and emits the state after each round on rsp_, with the
// round index in rsp_tuser and rsp_tlast marking the final round, whose data is the
// ciphertext. The state is loaded on acceptance, then each round goes through the shared
// round unit; no new item is taken until the last round is done. A stalled rsp_ side holds
// the sequencer, since each round result waits in the output register until it is taken.
module lea128_block_encrypt #(
   parameter int ROUND_COUNT = lea_pkg::DEF_ROUNDS
) (
   input  wire         clock,
   input  wire         reset,
   // Input items
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [127:0] req_tdata,   // plain_word_0, plain_word_1, plain_word_2, plain_word_3
   // Result items
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [127:0] rsp_tdata,  // round_word_0, round_word_1, round_word_2, round_word_3
   output logic [4:0]  rsp_tuser,   // round_number
   output logic        rsp_tlast,   // last_round
   // Configuration writes
   input  wire         csr_wr_en,
   input  wire [1:0]   csr_index,
   input  wire [31:0]  csr_wdata
);

   // Round count clamped to the supported range
   localparam int RoundsEff = (ROUND_COUNT < 1) ? 1 :
                              (ROUND_COUNT > lea_pkg::MAX_ROUNDS) ? lea_pkg::MAX_ROUNDS :
                              ROUND_COUNT;
   localparam lea_pkg::round_type LastRound = lea_pkg::round_type'(RoundsEff - 1);

   lea_pkg::quad_type  key_ff, key_in;
   lea_pkg::quad_type  x_ff, x_in;
   lea_pkg::quad_type  t_ff, t_in;
   lea_pkg::round_type round_ff, round_in;
   lea_pkg::state_type state_ff, state_in;
   logic               out_valid_ff, out_valid_in;
   lea_pkg::quad_type  out_data_ff, out_data_in;
   lea_pkg::round_type out_round_ff, out_round_in;
   logic               out_last_ff, out_last_in;

   lea_pkg::quad_type  x_nxt, t_nxt;
   logic               accept;
   logic               step;
   logic               is_last;

   // Shared round unit
   lea_round u_round (
      .round_idx (round_ff),
      .state_cur (x_ff),
      .key_cur   (t_ff),
      .state_nxt (x_nxt),
      .key_nxt   (t_nxt)
   );

   // Key register writes
   always_comb begin
      key_in = key_ff;
      if (csr_wr_en) begin
         unique case (lea_pkg::csr_index_type'(csr_index))
            lea_pkg::CSR_KEY_WORD_0: key_in[0] = csr_wdata;
            lea_pkg::CSR_KEY_WORD_1: key_in[1] = csr_wdata;
            lea_pkg::CSR_KEY_WORD_2: key_in[2] = csr_wdata;
            lea_pkg::CSR_KEY_WORD_3: key_in[3] = csr_wdata;
            default:                 key_in = key_ff;
         endcase
      end
   end

   // Handshake qualifiers
   assign accept  = req_tvalid && req_tready;
   assign step    = (state_ff == lea_pkg::ST_RUN) && (!out_valid_ff || rsp_tready);
   assign is_last = (round_ff == LastRound);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lea_pkg::ST_IDLE: if (accept) state_in = lea_pkg::ST_RUN;
         lea_pkg::ST_RUN:  if (step && is_last) state_in = lea_pkg::ST_IDLE;
         default:          state_in = lea_pkg::ST_IDLE;
      endcase
   end

   // Datapath and output register updates
   always_comb begin
      req_tready   = (state_ff == lea_pkg::ST_IDLE);
      x_in         = x_ff;
      t_in         = t_ff;
      round_in     = round_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_round_in = out_round_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         lea_pkg::ST_IDLE: begin
            if (accept) begin
               x_in     = req_tdata;
               t_in     = key_ff;
               round_in = '0;
            end
         end
         lea_pkg::ST_RUN: begin
            if (step) begin
               x_in         = x_nxt;
               t_in         = t_nxt;
               round_in     = round_ff + 5'd1;
               out_valid_in = 1'b1;
               out_data_in  = x_nxt;
               out_round_in = round_ff;
               out_last_in  = is_last;
            end
         end
         default: begin
            x_in = x_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lea_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         key_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         key_ff       <= key_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      t_ff         <= t_in;
      round_ff     <= round_in;
      out_data_ff  <= out_data_in;
      out_round_ff <= out_round_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_round_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

/* src/lea128_block_encrypt_chk.sv */
// Port-level checker for the LEA-128 encryption block, bound to its top level.
// Depends on lea_pkg for the default and maximum round counts.
`default_nettype none

module lea128_block_encrypt_chk #(
   parameter int ROUND_COUNT = lea_pkg::DEF_ROUNDS
) (
   input wire         clock,
   input wire         reset,
   input wire         req_tvalid,
   input wire         req_tready,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [127:0] rsp_tdata,
   input wire [4:0]   rsp_tuser,
   input wire         rsp_tlast
);

   localparam int RoundsEff = (ROUND_COUNT < 1) ? 1 :
                              (ROUND_COUNT > lea_pkg::MAX_ROUNDS) ? lea_pkg::MAX_ROUNDS :
                              ROUND_COUNT;
   localparam logic [4:0] LastRound = 5'(RoundsEff - 1);

   // No result item straight after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result item shown after reset");

   // A stalled result item holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result item changed");

   // The last item of a block carries the final round number.
   a_last_round: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == LastRound)))
      else $error("last flag and round number disagree");

   // Once an item is accepted the block stops taking items.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while a block is in progress");

   // An intermediate round is on the output only while its block is still running.
   a_busy_mid_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("ready for a new item before the block finished");

endmodule

bind lea128_block_encrypt lea128_block_encrypt_chk #(
   .ROUND_COUNT (ROUND_COUNT)
) u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
